/* hdl/olwd_pkg.sv */
// olwd_pkg: shared types and constants of the ordered list block
// command and status codes, write address selects, controller/datapath structs
// no dependencies
package olwd_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned STS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_END   = 2'd0,
    CMD_INS_BEGIN = 2'd1,
    CMD_DELETE    = 2'd2,
    CMD_DISPLAY   = 2'd3
  } command_e;

  typedef enum logic [STS_W-1:0] {
    STS_DONE      = 3'd0,
    STS_EMPTY     = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_FULL      = 3'd3,
    STS_ENTRY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    WR_TAIL,
    WR_HEAD,
    WR_PREV
  } wr_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    idx_clr;
    logic    idx_inc;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    head_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    status_e out_status;
    logic    out_entry;
    logic    out_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    command_e cmd;
    logic     empty;
    logic     full;
    logic     match;
    logic     idx_last;
    logic     out_free;
  } dp_sts_t;

endpackage

/* hdl/olwd_if.sv */
// olwd_in_if / olwd_out_if: valid/ready channels of the ordered list block
// depends on olwd_pkg for field widths
interface olwd_in_if;
  import olwd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] value;
  modport source(output valid, output command, output value, input ready);
  modport sink(input valid, input command, input value, output ready);
endinterface

interface olwd_out_if;
  import olwd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STS_W-1:0]        status;
  logic signed [VAL_W-1:0] entry_value;
  logic                    last;
  modport source(output valid, output status, output entry_value, output last, input ready);
  modport sink(input valid, input status, input entry_value, input last, output ready);
endinterface

/* hdl/olwd_dp.sv */
// olwd_dp: list storage (circular buffer memory), pointers and output register
// depends on olwd_pkg; driven by olwd_ctrl through dp_cmd_t
module olwd_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [olwd_pkg::CMD_W-1:0]       command_i,
  input  logic signed [olwd_pkg::VAL_W-1:0] value_i,
  input  olwd_pkg::dp_cmd_t                cmd_i,
  output olwd_pkg::dp_sts_t                sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [olwd_pkg::STS_W-1:0]       out_status_o,
  output logic signed [olwd_pkg::VAL_W-1:0] out_value_o,
  output logic                             out_last_o
);
  import olwd_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data_q;
  logic [VAL_W-1:0] value_q;
  logic [VAL_W-1:0] wr_data;
  command_e         cmd_q;

  logic [AW-1:0] head_q, head_d, head_dec;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [SW-1:0] prev_sum;

  logic             out_valid_q;
  logic [STS_W-1:0] out_status_q;
  logic [VAL_W-1:0] out_value_q;
  logic             out_last_q;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(CAPACITY)) ? s - SW'(CAPACITY) : s;
    return r[AW-1:0];
  endfunction

  assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  assign head_d   = cmd_i.head_dec ? head_dec : head_q;
  assign rd_addr  = wrap(SW'(head_q) + SW'(idx_d));
  assign prev_sum = SW'(head_q) + SW'(idx_q) - SW'(1);

  always_comb begin
    case (cmd_i.wr_sel)
      WR_TAIL: wr_addr = wrap(SW'(head_q) + SW'(count_q));
      WR_HEAD: wr_addr = head_dec;
      WR_PREV: wr_addr = wrap(prev_sum);
      default: wr_addr = head_q;
    endcase
  end

  assign wr_data = (cmd_i.wr_sel == WR_PREV) ? rd_data_q : value_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= command_e'(command_i);
      value_q <= value_i;
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_value_q  <= cmd_i.out_entry ? rd_data_q : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CW'(CAPACITY));
  assign sts_o.match    = (rd_data_q == value_q);
  assign sts_o.idx_last = ((SW'(idx_q) + SW'(1)) == SW'(count_q));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = $signed(out_value_q);
  assign out_last_o   = out_last_q;

endmodule

/* hdl/olwd_ctrl.sv */
// olwd_ctrl: sequencer for insert, delete scan/shift and display walk
// depends on olwd_pkg; commands olwd_dp through dp_cmd_t
module olwd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  olwd_pkg::dp_sts_t sts_i,
  output olwd_pkg::dp_cmd_t cmd_o
);
  import olwd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RESULT,
    S_SCAN,
    S_SHIFT,
    S_SHOW
  } state_e;

  state_e  state_q, state_d;
  status_e res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= STS_DONE;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.wr_sel     = WR_TAIL;
    cmd_o.out_status = STS_DONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.cmd)
          CMD_INS_END: begin
            state_d = S_RESULT;
            if (sts_i.full) begin
              res_d = STS_FULL;
            end else begin
              res_d         = STS_DONE;
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = WR_TAIL;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          CMD_INS_BEGIN: begin
            state_d = S_RESULT;
            if (sts_i.full) begin
              res_d = STS_FULL;
            end else begin
              res_d          = STS_DONE;
              cmd_o.wr_en    = 1'b1;
              cmd_o.wr_sel   = WR_HEAD;
              cmd_o.head_dec = 1'b1;
              cmd_o.cnt_inc  = 1'b1;
            end
          end
          CMD_DELETE: begin
            if (sts_i.empty) begin
              res_d   = STS_EMPTY;
              state_d = S_RESULT;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_SCAN;
            end
          end
          CMD_DISPLAY: begin
            if (sts_i.empty) begin
              res_d   = STS_EMPTY;
              state_d = S_RESULT;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_SHOW;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = res_q;
          cmd_o.out_last   = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.match) begin
          if (sts_i.idx_last) begin
            cmd_o.cnt_dec = 1'b1;
            res_d         = STS_DONE;
            state_d       = S_RESULT;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_SHIFT;
          end
        end else if (sts_i.idx_last) begin
          res_d   = STS_NOT_FOUND;
          state_d = S_RESULT;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_PREV;
        if (sts_i.idx_last) begin
          cmd_o.cnt_dec = 1'b1;
          res_d         = STS_DONE;
          state_d       = S_RESULT;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_SHOW: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = STS_ENTRY;
          cmd_o.out_entry  = 1'b1;
          cmd_o.out_last   = sts_i.idx_last;
          if (sts_i.idx_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* hdl/ordered_list_with_delete_by_value_core.sv */
// ordered_list_with_delete_by_value_core: bounded ordered list with delete by value
// depends on olwd_pkg, olwd_if, olwd_ctrl, olwd_dp
//
//  channel | dir | payload                      | per item
//  in_i    | in  | command, value               | one command
//  out_o   | out | status, entry_value, last    | one, or one per entry on display
//
// insert: written to the list in the dispatch state, result loaded from the result state
// delete: scans the memory up to the match, then moves each entry behind it
//   down by one place (single write and single registered read port of the list memory)
// display: walks the list from the head, one entry per cycle while out_o is ready
// reset clears count and pointers; the list memory itself is not cleared
// a stalled out_o holds the sequencer at its next result; in_i is taken only between items
module ordered_list_with_delete_by_value_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  olwd_in_if.sink           in_i,
  olwd_out_if.source        out_o
);
  import olwd_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  olwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  olwd_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (in_i.command),
    .value_i      (in_i.value),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_value_o  (out_o.entry_value),
    .out_last_o   (out_o.last)
  );

endmodule
